### rtl/core/euler_to_rotation_matrix_unit_assert.svh
// assertion macros for the euler to rotation matrix unit
// included by the top level, no other dependencies
`ifndef EULER_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define EULER_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define E2R_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define E2R_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define E2R_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define E2R_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

### rtl/core/e2r_pkg.sv
// shared constants, types and arctangent table for the euler to rotation matrix unit
// no dependencies
`default_nettype none
package e2r_pkg;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int ANG_W = 16;
    localparam int OUT_W = 16;
    localparam int XY_W = 34;
    localparam int Z_W = 28;
    localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [Z_W-1:0] PI_Q24 = 28'sd52707179;
    localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_lane_t;

    function automatic logic signed [Z_W-1:0] atan_q24(input int idx);
        logic signed [Z_W-1:0] r;
        begin
            case (idx)
                0: r = 28'sd13176795;
                1: r = 28'sd7778716;
                2: r = 28'sd4110060;
                3: r = 28'sd2086331;
                4: r = 28'sd1047214;
                5: r = 28'sd524117;
                6: r = 28'sd262123;
                7: r = 28'sd131069;
                default: r = (idx < ATAN_ENTRIES) ? (28'sd1 <<< (24 - idx)) : '0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

### rtl/core/e2r_cordic_cell.sv
// one cordic rotation cell: three angle lanes plus sideband, registered
// depends on e2r_pkg
`default_nettype none
module e2r_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire e2r_pkg::cordic_lane_t    lane_in  [3],
    input  wire logic [3:0]               side_in,
    output e2r_pkg::cordic_lane_t         lane_out [3],
    output logic [3:0]                    side_out
);
    import e2r_pkg::*;

    cordic_lane_t lane_reg [3];
    cordic_lane_t lane_next [3];
    logic [3:0] side_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (lane_in[k].z >= 0) begin
                lane_next[k].x = lane_in[k].x - (lane_in[k].y >>> STAGE);
                lane_next[k].y = lane_in[k].y + (lane_in[k].x >>> STAGE);
                lane_next[k].z = lane_in[k].z - atan_q24(STAGE);
            end else begin
                lane_next[k].x = lane_in[k].x + (lane_in[k].y >>> STAGE);
                lane_next[k].y = lane_in[k].y - (lane_in[k].x >>> STAGE);
                lane_next[k].z = lane_in[k].z + atan_q24(STAGE);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
            side_reg <= side_in;
        end
    end

    assign lane_out = lane_reg;
    assign side_out = side_reg;
endmodule
`default_nettype wire

### rtl/core/e2r_matrix.sv
// matrix builder: products of sines and cosines, rounding, saturation, transpose
// depends on e2r_pkg; four register stages
`default_nettype none
module e2r_matrix (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic signed [e2r_pkg::XY_W-1:0] sr, cr, sp, cp, sy, cy,
    input  wire logic                        mode,
    output logic [9*e2r_pkg::OUT_W-1:0]      mat
);
    import e2r_pkg::*;

    localparam int P_W = 2 * XY_W;

    // stage a: pair products and the rounded q30 terms
    logic signed [P_W-1:0] srsp_p, crsp_p;
    logic signed [XY_W-1:0] srsp_next, crsp_next;
    logic signed [XY_W-1:0] srsp_reg, crsp_reg;
    logic signed [XY_W-1:0] a_sr_reg, a_cr_reg, a_sp_reg, a_cp_reg, a_sy_reg, a_cy_reg;
    logic a_mode_reg;

    assign srsp_p = sr * sp;
    assign crsp_p = cr * sp;
    assign srsp_next = XY_W'((srsp_p + (P_W'(1) <<< 29)) >>> 30);
    assign crsp_next = XY_W'((crsp_p + (P_W'(1) <<< 29)) >>> 30);

    always_ff @(posedge aclk) begin
        if (en) begin
            srsp_reg <= srsp_next;
            crsp_reg <= crsp_next;
            a_sr_reg <= sr;
            a_cr_reg <= cr;
            a_sp_reg <= sp;
            a_cp_reg <= cp;
            a_sy_reg <= sy;
            a_cy_reg <= cy;
            a_mode_reg <= mode;
        end
    end

    // stage b: all q60 products
    logic signed [P_W-1:0] prod_reg [14];
    logic signed [P_W-1:0] prod_next [14];
    logic b_mode_reg;

    always_comb begin
        prod_next[0]  = a_cp_reg * a_cy_reg;
        prod_next[1]  = a_cr_reg * a_sy_reg;
        prod_next[2]  = srsp_reg * a_cy_reg;
        prod_next[3]  = a_sr_reg * a_sy_reg;
        prod_next[4]  = crsp_reg * a_cy_reg;
        prod_next[5]  = a_cp_reg * a_sy_reg;
        prod_next[6]  = a_cr_reg * a_cy_reg;
        prod_next[7]  = srsp_reg * a_sy_reg;
        prod_next[8]  = a_sr_reg * a_cy_reg;
        prod_next[9]  = crsp_reg * a_sy_reg;
        prod_next[10] = P_W'(a_sp_reg) <<< 30;
        prod_next[11] = a_sr_reg * a_cp_reg;
        prod_next[12] = a_cr_reg * a_cp_reg;
        prod_next[13] = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            b_mode_reg <= a_mode_reg;
        end
    end

    // stage c: sums in q60
    logic signed [P_W-1:0] sum_reg [9];
    logic signed [P_W-1:0] sum_next [9];
    logic c_mode_reg;

    always_comb begin
        sum_next[0] = prod_reg[0];
        sum_next[1] = prod_reg[2] - prod_reg[1];
        sum_next[2] = prod_reg[3] + prod_reg[4];
        sum_next[3] = prod_reg[5];
        sum_next[4] = prod_reg[6] + prod_reg[7];
        sum_next[5] = prod_reg[9] - prod_reg[8];
        sum_next[6] = prod_reg[13] - prod_reg[10];
        sum_next[7] = prod_reg[11];
        sum_next[8] = prod_reg[12];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
            c_mode_reg <= b_mode_reg;
        end
    end

    // stage d: round, saturate, optional transpose
    logic signed [P_W-1:0] rnd [9];
    logic signed [OUT_W-1:0] sat [9];
    logic [9*OUT_W-1:0] mat_next;
    logic [9*OUT_W-1:0] mat_reg;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            rnd[k] = (sum_reg[k] + (P_W'(1) <<< 45)) >>> 46;
            if (rnd[k] > P_W'(16384)) begin
                sat[k] = 16'sd16384;
            end else if (rnd[k] < -P_W'(16384)) begin
                sat[k] = -16'sd16384;
            end else begin
                sat[k] = OUT_W'(rnd[k]);
            end
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mat_next[(r*3+c)*OUT_W +: OUT_W] = c_mode_reg ? sat[c*3+r] : sat[r*3+c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;
endmodule
`default_nettype wire

### rtl/core/euler_to_rotation_matrix_unit.sv
// channel | dir | tdata fields (low bit first)          | tuser
// s_axis  | in  | roll, pitch, yaw (3 x 16)              | mode
// m_axis  | out | m00 m01 m02 m10 m11 m12 m20 m21 m22    | -
// one beat per cycle while m_axis does not stall; the path runs through the fold stage, the cordic cells
// and the four matrix stages, NCELL being CORDIC_STAGES capped at 24. the whole pipe
// advances when the output register is free or taken, so a stall on m_axis
// holds every cell. reset clears valid bits only.
// depends on e2r_pkg, e2r_cordic_cell, e2r_matrix and the assert header
`default_nettype none
`include "euler_to_rotation_matrix_unit_assert.svh"
module euler_to_rotation_matrix_unit #(
    parameter int CORDIC_STAGES = e2r_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [47:0]   s_axis_tdata,  // roll[15:0], pitch[31:16], yaw[47:32]
    input  wire logic          s_axis_tuser,  // mode
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [143:0]       m_axis_tdata   // m00, m01, m02, m10, m11, m12, m20, m21, m22
);
    import e2r_pkg::*;

    localparam int NCELL = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int LAT = NCELL + 5;

    logic en;
    logic [LAT-1:0] vld_reg;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // fold stage
    cordic_lane_t fold_reg [3];
    cordic_lane_t fold_next [3];
    logic [2:0] flip_next;
    logic [3:0] side0_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [Z_W-1:0] z;
            z = Z_W'(signed'(s_axis_tdata[k*ANG_W +: ANG_W])) <<< 11;
            flip_next[k] = 1'b0;
            if (z > HALF_PI_Q24) begin
                z = z - PI_Q24;
                flip_next[k] = 1'b1;
            end else if (z < -HALF_PI_Q24) begin
                z = z + PI_Q24;
                flip_next[k] = 1'b1;
            end
            fold_next[k].x = GAIN_Q30;
            fold_next[k].y = '0;
            fold_next[k].z = z;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fold_reg <= fold_next;
            side0_reg <= {s_axis_tuser, flip_next};
        end
    end

    cordic_lane_t chain_lane [NCELL+1][3];
    logic [3:0] chain_side [NCELL+1];
    assign chain_lane[0] = fold_reg;
    assign chain_side[0] = side0_reg;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        e2r_cordic_cell #(.STAGE(g)) u_cell (
            .aclk    (aclk),
            .en      (en),
            .lane_in (chain_lane[g]),
            .side_in (chain_side[g]),
            .lane_out(chain_lane[g+1]),
            .side_out(chain_side[g+1])
        );
    end

    logic signed [XY_W-1:0] sn [3];
    logic signed [XY_W-1:0] cs [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cs[k] = chain_side[NCELL][k] ? -chain_lane[NCELL][k].x : chain_lane[NCELL][k].x;
            sn[k] = chain_side[NCELL][k] ? -chain_lane[NCELL][k].y : chain_lane[NCELL][k].y;
        end
    end

    e2r_matrix u_matrix (
        .aclk(aclk),
        .en  (en),
        .sr  (sn[0]),
        .cr  (cs[0]),
        .sp  (sn[1]),
        .cp  (cs[1]),
        .sy  (sn[2]),
        .cy  (cs[2]),
        .mode(chain_side[NCELL][3]),
        .mat (m_axis_tdata)
    );

    `E2R_ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_axis_tvalid |-> s_axis_tready, "ready low with empty output")
    `E2R_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(vld_reg), "pipe moved during stall")
    `E2R_ASSERT_NEXT(a_flow, aclk, aresetn, s_axis_tvalid && s_axis_tready, vld_reg[0], "accepted beat not tracked")
endmodule
`default_nettype wire
